// ===== design/zswc_pkg.sv =====
// Shared types and constants for the ZMODEM send window control block.
package zswc_pkg;

   // Subpacket size is halved on a retry only while it is above this floor
   localparam int unsigned SUBPACKET_FLOOR = 128;
   // A query is sent each time a quarter window has passed
   localparam int unsigned ACK_INTERVAL_SHIFT = 2;

   // Command queue between front and back
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam int unsigned CSR_INDEX_W = 3;

   typedef enum logic [1:0] {
      OP_START = 2'd0,
      OP_BLOCK = 2'd1,
      OP_ACK   = 2'd2,
      OP_RETRY = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      FE_NONE  = 3'd0,
      FE_END   = 3'd1,
      FE_WAIT  = 3'd2,
      FE_QUERY = 3'd3,
      FE_GO    = 3'd4
   } frame_end_type;

   typedef enum logic [1:0] {
      ACK_OK      = 2'd0,
      ACK_BEYOND  = 2'd1,
      ACK_IGNORED = 2'd2
   } ack_status_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_WINDOW         = 3'd0,
      CSR_RX_BUFFER      = 3'd1,
      CSR_CEILING        = 3'd2,
      CSR_STREAM_DISABLE = 3'd3,
      CSR_FULL_DUPLEX    = 3'd4,
      CSR_OVERLAP_IO     = 3'd5
   } csr_index_type;

   // Input word
   typedef struct packed {
      logic [1:0]  mode;
      logic [31:0] position;
      logic [13:0] count;
      logic        eof_flag;
   } req_word_type;

   // Result word
   typedef struct packed {
      logic [2:0]  fend_kind;
      logic        header_needed;
      logic [13:0] next_read_len;
      logic        window_full;
      logic [1:0]  ack_status;
      logic        file_done;
      logic [31:0] tx_position;
   } rsp_word_type;

   // Classified command held in the queue
   typedef struct packed {
      op_type      op;
      logic [31:0] position;
      logic [13:0] count;
      logic        eof_flag;
   } cmd_type;

   // Register write toward the back end
   typedef struct packed {
      logic                   write;
      logic [CSR_INDEX_W-1:0] index;
      logic [31:0]            data;
   } csr_write_type;

endpackage

// ===== design/zmodem_send_window_control.sv =====
// Top level of the ZMODEM send window control block.
//
// Sender-side flow control for the ZMODEM data phase. Each input word on
// the req_ channel is one event (start, block read, acknowledgement or
// retry) and yields exactly one result word on the rsp_ channel: frame end
// kind, header request, next read size, window full, ack verdict, done
// flag and the sent position.
// A word moves when valid is high and stall is low. The front end takes a
// word into a two-entry command queue; the back end executes one command
// per cycle unless its result registers are held; the result passes a
// verdict register and then an output register. One word per cycle is
// sustained while rsp_stall is low; the back end's state update sets
// that rate. When rsp_stall is held, the output and verdict registers
// fill, then the queue, after which req_stall rises; nothing is dropped.
// Registers are written on the csr_ port (always ready) while idle, a
// rule for the user that the block does not enforce. Synchronous reset
// clears the queue, the pipeline and the window state; the subpacket
// size restarts at its minimum ceiling.
module zmodem_send_window_control import zswc_pkg::*; #(
   parameter int unsigned MIN_CEILING   = 1024,
   parameter int unsigned MAX_SUBPACKET = 8192
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_word_type           req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_word_type           rsp_word,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]            csr_wdata
);

   logic          push, queue_full, pop, head_valid;
   cmd_type       push_cmd, head_cmd;
   csr_write_type csr;

   assign csr_ready = 1'b1;
   assign csr.write = csr_valid && csr_ready;
   assign csr.index = csr_index;
   assign csr.data  = csr_wdata;

   zswc_front u_front (
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .queue_full(queue_full),
      .push      (push),
      .push_cmd  (push_cmd)
   );

   zswc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .full      (queue_full),
      .pop       (pop),
      .head_valid(head_valid),
      .head_cmd  (head_cmd)
   );

   zswc_back #(
      .MIN_CEILING  (MIN_CEILING),
      .MAX_SUBPACKET(MAX_SUBPACKET)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .csr      (csr),
      .cmd_valid(head_valid),
      .cmd      (head_cmd),
      .cmd_pop  (pop),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_word (rsp_word)
   );

   // A wait frame leaves nothing to read until its ack arrives
   a_wait_blocks_read: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_word.fend_kind == FE_WAIT) |-> (rsp_word.next_read_len == '0))
      else $error("read offered after a wait frame");

   // A full window offers no read
   a_full_blocks_read: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.window_full |-> (rsp_word.next_read_len == '0))
      else $error("read offered while window is full");

   // An acknowledgement verdict never comes with a frame end
   a_ack_no_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_word.ack_status != ACK_OK) |-> (rsp_word.fend_kind == FE_NONE))
      else $error("frame end reported with an ack verdict");

endmodule

// ===== design/zswc_front.sv =====
// Front end: accepts input words and classifies them into queue commands.
module zswc_front import zswc_pkg::*; (
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   input  logic         queue_full,
   output logic         push,
   output cmd_type      push_cmd
);

   op_type op;

   assign op        = op_type'(req_word.mode);
   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   // Keep only the fields each event kind gives meaning to
   always_comb begin
      push_cmd = '0;
      push_cmd.op = op;
      unique case (op) inside
         OP_START, OP_ACK: begin
            push_cmd.position = req_word.position;
         end
         OP_BLOCK: begin
            push_cmd.count    = req_word.count;
            push_cmd.eof_flag = req_word.eof_flag;
         end
         OP_RETRY: begin
         end
         default: begin
         end
      endcase
   end

endmodule

// ===== design/zswc_queue.sv =====
// Short command queue between the front and back ends.
module zswc_queue import zswc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    head_valid,
   output cmd_type head_cmd
);

   cmd_type                mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;

   assign full       = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = mem_ff[rd_ptr_ff];

   // Pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== design/zswc_back.sv =====
// Back end: window state, event execution and the result pipeline.
module zswc_back import zswc_pkg::*; #(
   parameter int unsigned MIN_CEILING   = 1024,
   parameter int unsigned MAX_SUBPACKET = 8192
) (
   input  logic          clock,
   input  logic          reset,
   input  csr_write_type csr,
   input  logic          cmd_valid,
   input  cmd_type       cmd,
   output logic          cmd_pop,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output rsp_word_type  rsp_word
);

   localparam int unsigned SW = $clog2(MAX_SUBPACKET + 1);

   // Configuration
   logic [31:0] window_ff;
   logic [15:0] rx_buffer_ff;
   logic        stream_disable_ff;
   logic        full_duplex_ff;
   logic        overlap_io_ff;

   // Window state
   logic [31:0]   sent_pos_ff, sent_pos_in;
   logic [31:0]   acked_pos_ff, acked_pos_in;
   logic [31:0]   last_req_ff, last_req_in;
   logic [16:0]   segment_ff, segment_in;
   logic [SW-1:0] sub_now_ff, sub_now_in;
   logic [SW-1:0] sub_ceil_ff, sub_ceil_in;
   logic          frm_open_ff, frm_open_in;
   logic          await_ff, await_in;
   logic          eof_pend_ff, eof_pend_in;

   // Result pipeline
   logic           mid_valid_ff, mid_valid_in;
   frame_end_type  mid_fe_ff, mid_fe_in;
   ack_status_type mid_ack_ff, mid_ack_in;
   logic           mid_done_ff, mid_done_in;
   logic           out_valid_ff, out_valid_in;
   rsp_word_type   out_word_ff;

   // Derived values
   logic          windowing, wait_each, win_full;
   logic [31:0]   inflight, room, rs32, offer32;
   logic [16:0]   rx_room;
   logic [SW-1:0] offer;
   logic [13:0]   ceil_wr;
   logic [SW-1:0] ceil_clamp;
   logic [31:0]   n32;
   logic [31:0]   next_pos;
   logic [16:0]   seg_sum;
   logic [SW-1:0] grown;
   logic [SW:0]   doubled;
   logic          out_load, mid_adv, fire;

   assign windowing = (window_ff != '0) && full_duplex_ff;
   assign wait_each = stream_disable_ff || !overlap_io_ff ||
                      ((window_ff != '0) && !full_duplex_ff);

   // Read offer from the current state
   always_comb begin
      inflight = sent_pos_ff - acked_pos_ff;
      win_full = windowing && (inflight >= window_ff);
      room     = window_ff - inflight;
      rx_room  = ({1'b0, rx_buffer_ff} > segment_ff) ? {1'b0, rx_buffer_ff} - segment_ff : '0;
      rs32     = 32'(sub_now_ff);
      if (windowing && (rs32 > room)) begin
         rs32 = room;
      end
      if ((rx_buffer_ff != '0) && (rs32 > 32'(rx_room))) begin
         rs32 = 32'(rx_room);
      end
      offer32 = (await_ff || win_full) ? '0 : rs32;
      offer   = SW'(offer32);
   end

   // Doubled subpacket size, held at the ceiling
   always_comb begin
      doubled = {sub_now_ff, 1'b0};
      grown   = sub_now_ff;
      if (sub_now_ff < sub_ceil_ff) begin
         grown = (doubled > {1'b0, sub_ceil_ff}) ? sub_ceil_ff : doubled[SW-1:0];
      end
   end

   // Ceiling write saturated into the legal range
   always_comb begin
      ceil_wr = csr.data[13:0];
      if (32'(ceil_wr) < MIN_CEILING) begin
         ceil_clamp = SW'(MIN_CEILING);
      end else if (32'(ceil_wr) > MAX_SUBPACKET) begin
         ceil_clamp = SW'(MAX_SUBPACKET);
      end else begin
         ceil_clamp = SW'(ceil_wr);
      end
   end

   // Handshake through mid and output stages
   assign out_load = !out_valid_ff || !rsp_stall;
   assign mid_adv  = mid_valid_ff && out_load;
   assign fire     = cmd_valid && (!mid_valid_ff || mid_adv);
   assign cmd_pop  = fire;

   always_comb begin
      mid_valid_in = fire ? 1'b1 : (mid_adv ? 1'b0 : mid_valid_ff);
      out_valid_in = mid_adv ? 1'b1 : (out_load ? 1'b0 : out_valid_ff);
   end

   // Event execution
   always_comb begin
      sent_pos_in  = sent_pos_ff;
      acked_pos_in = acked_pos_ff;
      last_req_in  = last_req_ff;
      segment_in   = segment_ff;
      sub_now_in   = sub_now_ff;
      sub_ceil_in  = sub_ceil_ff;
      frm_open_in  = frm_open_ff;
      await_in     = await_ff;
      eof_pend_in  = eof_pend_ff;
      mid_fe_in    = FE_NONE;
      mid_ack_in   = ACK_OK;
      mid_done_in  = 1'b0;

      // Clip count by the offer and by the end of the position space
      n32 = 32'(cmd.count);
      if (n32 > offer32) begin
         n32 = offer32;
      end
      if (n32 > ~sent_pos_ff) begin
         n32 = ~sent_pos_ff;
      end
      next_pos = sent_pos_ff + n32;
      seg_sum  = segment_ff + n32[16:0];

      if (csr.write && (csr.index == CSR_CEILING)) begin
         sub_ceil_in = ceil_clamp;
         if (sub_now_ff > ceil_clamp) begin
            sub_now_in = ceil_clamp;
         end
      end

      if (fire) begin
         unique case (cmd.op)
            OP_START: begin
               sent_pos_in  = cmd.position;
               acked_pos_in = cmd.position;
               last_req_in  = cmd.position;
               segment_in   = '0;
               frm_open_in  = 1'b0;
               await_in     = 1'b0;
               eof_pend_in  = 1'b0;
            end
            OP_BLOCK: begin
               if (offer != '0) begin
                  sent_pos_in = next_pos;
                  frm_open_in = 1'b1;
                  if ((n32 == '0) || (!wait_each && cmd.eof_flag)) begin
                     mid_fe_in   = FE_END;
                     frm_open_in = 1'b0;
                     mid_done_in = 1'b1;
                  end else begin
                     segment_in = seg_sum;
                     if (wait_each ||
                         ((rx_buffer_ff != '0) && (seg_sum == {1'b0, rx_buffer_ff}))) begin
                        mid_fe_in   = FE_WAIT;
                        await_in    = 1'b1;
                        eof_pend_in = wait_each && cmd.eof_flag;
                     end else begin
                        if (windowing &&
                            ((next_pos - last_req_ff) >= (window_ff >> ACK_INTERVAL_SHIFT))) begin
                           mid_fe_in   = FE_QUERY;
                           last_req_in = next_pos;
                        end else begin
                           mid_fe_in = FE_GO;
                        end
                        sub_now_in = grown;
                     end
                  end
               end
            end
            OP_ACK: begin
               if (await_ff) begin
                  if (cmd.position == sent_pos_ff) begin
                     acked_pos_in = sent_pos_ff;
                     last_req_in  = sent_pos_ff;
                     frm_open_in  = 1'b0;
                     segment_in   = '0;
                     await_in     = 1'b0;
                     sub_now_in   = grown;
                     mid_done_in  = eof_pend_ff;
                     eof_pend_in  = 1'b0;
                  end else begin
                     mid_ack_in = ACK_IGNORED;
                  end
               end else if (cmd.position > sent_pos_ff) begin
                  mid_ack_in = ACK_BEYOND;
               end else if (cmd.position > acked_pos_ff) begin
                  acked_pos_in = cmd.position;
               end
            end
            OP_RETRY: begin
               if ((sub_now_ff == sub_ceil_ff) && (32'(sub_ceil_ff) > MIN_CEILING)) begin
                  sub_ceil_in = sub_ceil_ff >> 1;
               end
               if (32'(sub_now_ff) > SUBPACKET_FLOOR) begin
                  sub_now_in = sub_now_ff >> 1;
               end
               frm_open_in = 1'b0;
               segment_in  = '0;
               await_in    = 1'b0;
               eof_pend_in = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff         <= '0;
         rx_buffer_ff      <= '0;
         stream_disable_ff <= 1'b0;
         full_duplex_ff    <= 1'b0;
         overlap_io_ff     <= 1'b0;
      end else if (csr.write) begin
         unique case (csr.index)
            CSR_WINDOW:         window_ff         <= csr.data;
            CSR_RX_BUFFER:      rx_buffer_ff      <= csr.data[15:0];
            CSR_STREAM_DISABLE: stream_disable_ff <= csr.data[0];
            CSR_FULL_DUPLEX:    full_duplex_ff    <= csr.data[0];
            CSR_OVERLAP_IO:     overlap_io_ff     <= csr.data[0];
            default: begin
            end
         endcase
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sent_pos_ff  <= '0;
         acked_pos_ff <= '0;
         last_req_ff  <= '0;
         segment_ff   <= '0;
         sub_now_ff   <= SW'(MIN_CEILING);
         sub_ceil_ff  <= (1024 < MIN_CEILING) ? SW'(MIN_CEILING) :
                         (1024 > MAX_SUBPACKET) ? SW'(MAX_SUBPACKET) : SW'(1024);
         frm_open_ff  <= 1'b0;
         await_ff     <= 1'b0;
         eof_pend_ff  <= 1'b0;
         mid_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         sent_pos_ff  <= sent_pos_in;
         acked_pos_ff <= acked_pos_in;
         last_req_ff  <= last_req_in;
         segment_ff   <= segment_in;
         sub_now_ff   <= sub_now_in;
         sub_ceil_ff  <= sub_ceil_in;
         frm_open_ff  <= frm_open_in;
         await_ff     <= await_in;
         eof_pend_ff  <= eof_pend_in;
         mid_valid_ff <= mid_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Mid stage holds the event verdict; the state already reflects the event
   always_ff @(posedge clock) begin
      if (fire) begin
         mid_fe_ff   <= mid_fe_in;
         mid_ack_ff  <= mid_ack_in;
         mid_done_ff <= mid_done_in;
      end
   end

   // Output word: verdict plus the plan for the next read
   always_ff @(posedge clock) begin
      if (mid_adv) begin
         out_word_ff.fend_kind     <= mid_fe_ff;
         out_word_ff.header_needed <= (offer != '0) && !frm_open_ff;
         out_word_ff.next_read_len <= 14'(offer);
         out_word_ff.window_full   <= !await_ff && win_full;
         out_word_ff.ack_status    <= mid_ack_ff;
         out_word_ff.file_done     <= mid_done_ff;
         out_word_ff.tx_position   <= sent_pos_ff;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_word_ff;

endmodule
